/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked during reset too.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/upng_pkg.sv */
// Types, constants and helper functions of the PNG stream encoder.
`default_nettype none
package upng_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       file_end;
    } t_byte_out;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_DIV1, ST_MUL1, ST_MUL2, ST_DIV2, ST_LEN, ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        PH_SIG, PH_IHDR_LEN, PH_IHDR, PH_IHDR_CRC, PH_IDAT_LEN, PH_IDAT_TAG,
        PH_BLK_HDR, PH_FILTER, PH_PIX, PH_ADLER, PH_IDAT_CRC, PH_IEND, PH_DONE
    } t_phase;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [63:0] PNG_SIG    = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IHDR_LEN   = 32'd13;
    localparam logic [31:0] IHDR_TAG   = 32'h49484452;
    localparam logic [31:0] IDAT_TAG   = 32'h49444154;
    localparam logic [31:0] IEND_TAG   = 32'h49454E44;
    localparam logic [31:0] IEND_CRC   = 32'hAE426082;
    localparam logic [7:0]  BIT_DEPTH  = 8'h08;
    localparam logic [7:0]  COLOR_TYPE = 8'h02;
    localparam logic [7:0]  ZLIB_CMF   = 8'h08;
    localparam logic [7:0]  ZLIB_FLG   = 8'h1D;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] be32(input logic [31:0] v, input logic [1:0] i);
        return 8'(v >> {2'd3 - i, 3'b000});
    endfunction

    function automatic logic [4:0] phase_last(input t_phase p);
        case (p)
            PH_SIG:      return 5'd7;
            PH_IHDR:     return 5'd16;
            PH_IDAT_TAG: return 5'd5;
            PH_BLK_HDR:  return 5'd4;
            PH_FILTER:   return 5'd0;
            PH_PIX:      return 5'd2;
            PH_IEND:     return 5'd11;
            PH_DONE:     return 5'd0;
            default:     return 5'd3;
        endcase
    endfunction

    function automatic t_phase phase_next(input t_phase p, input logic finish);
        case (p)
            PH_SIG:      return PH_IHDR_LEN;
            PH_IHDR_LEN: return PH_IHDR;
            PH_IHDR:     return PH_IHDR_CRC;
            PH_IHDR_CRC: return PH_IDAT_LEN;
            PH_IDAT_LEN: return PH_IDAT_TAG;
            PH_IDAT_TAG: return PH_BLK_HDR;
            PH_BLK_HDR:  return PH_FILTER;
            PH_FILTER:   return PH_PIX;
            PH_PIX:      return finish ? PH_ADLER : PH_DONE;
            PH_ADLER:    return PH_IDAT_CRC;
            PH_IDAT_CRC: return PH_IEND;
            default:     return PH_DONE;
        endcase
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/uncompressed_png_stream_encoder.sv */
// Top level: RGB pixel stream in, uncompressed PNG byte stream out.
//
//  channel | direction | handshake                     | payload
//  pixel   | in        | i_pix_valid / o_pix_ready     | i_pix  (t_pix_in)
//  byte    | out       | o_byte_valid / i_byte_ready   | o_byte (t_byte_out)
//  config  | in        | i_cfg_we (no wait)            | i_cfg_idx, i_cfg_data
//
// A pixel is accepted, then its bytes are emitted; no new pixel is taken until its run is finished.
// The first pixel of an image adds a setup phase that runs two 16-step divides
// on one shared restoring divider (rows per block, blocks per image).
// Bytes leave through one output register; a stall there pauses the sequencer.
// Reset is synchronous: control state clears, the registers return to 1x1.
`default_nettype none
module uncompressed_png_stream_encoder
    import upng_pkg::*;
#(
    parameter int MAX_DIMENSION   = 4096,
    parameter int MAX_BLOCK_BYTES = 65535
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_pix_valid,
    output logic                       o_pix_ready,
    input  wire t_pix_in               i_pix,
    output logic                       o_byte_valid,
    input  wire logic                  i_byte_ready,
    output t_byte_out                  o_byte,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WIDTH_LIMIT = (MAX_BLOCK_BYTES - 2) / 3;
    localparam int W_LIM = (MAX_DIMENSION < WIDTH_LIMIT) ? MAX_DIMENSION : WIDTH_LIMIT;
    localparam int H_LIM = MAX_DIMENSION;
    localparam logic [15:0] BLOCK_MAX = 16'(MAX_BLOCK_BYTES);

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [4:0] r_idx, n_idx;

    logic [CFG_DATA_W-1:0] r_img_w, r_img_h;
    logic        r_started;
    logic [12:0] r_col, r_row;
    logic        r_fend, r_trunc;
    t_pix_in     r_pix;

    logic [15:0] r_row_sz, r_rpb, r_full, r_block_left;
    logic [31:0] r_data_left, r_chunk, r_crc;
    logic [15:0] r_alo, r_ahi;

    logic [15:0] r_dq, r_rem, r_dvs;
    logic [3:0]  r_cnt;

    t_byte_out r_out;
    logic      r_ovalid;

    // clamped image size
    logic [12:0] w_wc, w_hc;
    always_comb begin
        if (r_img_w == '0) begin
            w_wc = 13'd1;
        end else if ({19'd0, r_img_w} > 32'(W_LIM)) begin
            w_wc = 13'(W_LIM);
        end else begin
            w_wc = r_img_w;
        end
        if (r_img_h == '0) begin
            w_hc = 13'd1;
        end else if ({19'd0, r_img_h} > 32'(H_LIM)) begin
            w_hc = 13'(H_LIM);
        end else begin
            w_hc = r_img_h;
        end
    end

    // accept-time position bookkeeping
    logic        w_accept;
    logic [13:0] w_col_next, w_row_next;
    logic        w_row_end, w_frame_end;
    assign w_accept    = i_pix_valid && o_pix_ready;
    assign w_col_next  = {1'b0, r_col} + 14'd1;
    assign w_row_next  = {1'b0, r_row} + 14'd1;
    assign w_row_end   = w_col_next >= {1'b0, w_wc};
    assign w_frame_end = w_row_end && (w_row_next >= {1'b0, w_hc});

    // shared restoring divider step
    logic [16:0] w_div_t;
    logic        w_div_ge;
    logic [15:0] w_div_rem;
    assign w_div_t   = {r_rem, r_dq[15]};
    assign w_div_ge  = w_div_t >= {1'b0, r_dvs};
    assign w_div_rem = w_div_ge ? 16'(w_div_t - {1'b0, r_dvs}) : w_div_t[15:0];

    logic [31:0] w_full_prod;
    assign w_full_prod = {16'd0, r_rpb} * {16'd0, r_row_sz};

    // block header fields
    logic [15:0] w_bsize;
    logic        w_blast;
    assign w_blast = r_data_left <= {16'd0, r_full};
    assign w_bsize = (r_data_left < {16'd0, r_full}) ? r_data_left[15:0] : r_full;

    logic w_finish;
    assign w_finish = r_fend && !r_trunc;

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_idx   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    if (!r_started) begin
                        n_state = ST_PREP;
                        n_phase = PH_SIG;
                    end else begin
                        n_state = ST_EMIT;
                        if (r_col != '0) begin
                            n_phase = PH_PIX;
                        end else if (r_block_left == '0) begin
                            n_phase = PH_BLK_HDR;
                        end else begin
                            n_phase = PH_FILTER;
                        end
                    end
                end
            end
            ST_PREP: n_state = ST_DIV1;
            ST_DIV1: if (r_cnt == 4'd15) n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_DIV2;
            ST_DIV2: if (r_cnt == 4'd15) n_state = ST_LEN;
            ST_LEN:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_ovalid || i_byte_ready) begin
                    if (r_idx == phase_last(r_phase)) begin
                        n_idx   = '0;
                        n_phase = phase_next(r_phase, w_finish);
                        if (n_phase == PH_DONE) n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + 5'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // byte selection and engine controls
    logic       w_emit, w_last, w_crc_en, w_adler_en, w_data_en, w_crc_init;
    logic [7:0] w_byte;
    always_comb begin
        w_emit     = (r_state == ST_EMIT) && (!r_ovalid || i_byte_ready);
        w_last     = (r_idx == phase_last(r_phase))
                     && (phase_next(r_phase, w_finish) == PH_DONE);
        w_crc_en   = 1'b0;
        w_adler_en = 1'b0;
        w_data_en  = 1'b0;
        w_crc_init = 1'b0;
        w_byte     = 8'd0;
        case (r_phase)
            PH_SIG: w_byte = 8'(PNG_SIG >> {3'd7 - r_idx[2:0], 3'b000});
            PH_IHDR_LEN: begin
                w_byte     = be32(IHDR_LEN, r_idx[1:0]);
                w_crc_init = 1'b1;
            end
            PH_IHDR: begin
                w_crc_en = 1'b1;
                case (r_idx[4:2])
                    3'd0:    w_byte = be32(IHDR_TAG, r_idx[1:0]);
                    3'd1:    w_byte = be32({19'd0, w_wc}, r_idx[1:0]);
                    3'd2:    w_byte = be32({19'd0, w_hc}, r_idx[1:0]);
                    3'd3: begin
                        case (r_idx[1:0])
                            2'd0:    w_byte = BIT_DEPTH;
                            2'd1:    w_byte = COLOR_TYPE;
                            default: w_byte = 8'd0;
                        endcase
                    end
                    default: w_byte = 8'd0;
                endcase
            end
            PH_IHDR_CRC, PH_IDAT_CRC: w_byte = be32(~r_crc, r_idx[1:0]);
            PH_IDAT_LEN: begin
                w_byte     = be32(r_chunk, r_idx[1:0]);
                w_crc_init = 1'b1;
            end
            PH_IDAT_TAG: begin
                w_crc_en = 1'b1;
                case (r_idx[2:0])
                    3'd4:    w_byte = ZLIB_CMF;
                    3'd5:    w_byte = ZLIB_FLG;
                    default: w_byte = be32(IDAT_TAG, r_idx[1:0]);
                endcase
            end
            PH_BLK_HDR: begin
                w_crc_en = 1'b1;
                case (r_idx[2:0])
                    3'd0:    w_byte = {7'd0, w_blast};
                    3'd1:    w_byte = w_bsize[7:0];
                    3'd2:    w_byte = w_bsize[15:8];
                    3'd3:    w_byte = ~w_bsize[7:0];
                    default: w_byte = ~w_bsize[15:8];
                endcase
            end
            PH_FILTER: begin
                w_crc_en   = 1'b1;
                w_adler_en = 1'b1;
                w_data_en  = 1'b1;
            end
            PH_PIX: begin
                w_crc_en   = 1'b1;
                w_adler_en = 1'b1;
                w_data_en  = 1'b1;
                case (r_idx[1:0])
                    2'd0:    w_byte = r_pix.red;
                    2'd1:    w_byte = r_pix.green;
                    default: w_byte = r_pix.blue;
                endcase
            end
            PH_ADLER: begin
                w_crc_en = 1'b1;
                w_byte   = be32({r_ahi, r_alo}, r_idx[1:0]);
            end
            PH_IEND: begin
                case (r_idx[3:2])
                    2'd1:    w_byte = be32(IEND_TAG, r_idx[1:0]);
                    2'd2:    w_byte = be32(IEND_CRC, r_idx[1:0]);
                    default: w_byte = 8'd0;
                endcase
            end
            default: w_byte = 8'd0;
        endcase
    end

    // Adler-32 add and fold
    logic [16:0] w_s1, w_s2;
    logic [15:0] w_alo, w_ahi;
    assign w_s1  = {1'b0, r_alo} + {9'd0, w_byte};
    assign w_alo = (w_s1 >= ADLER_MOD) ? 16'(w_s1 - ADLER_MOD) : w_s1[15:0];
    assign w_s2  = {1'b0, r_ahi} + {1'b0, w_alo};
    assign w_ahi = (w_s2 >= ADLER_MOD) ? 16'(w_s2 - ADLER_MOD) : w_s2[15:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_DONE;
            r_idx     <= '0;
            r_img_w   <= 13'd1;
            r_img_h   <= 13'd1;
            r_started <= 1'b0;
            r_col     <= '0;
            r_row     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            // drop writes that land inside an image
            if (i_cfg_we && !r_started) begin
                case (i_cfg_idx)
                    CFG_WIDTH:  r_img_w <= i_cfg_data;
                    CFG_HEIGHT: r_img_h <= i_cfg_data;
                    default:    ;
                endcase
            end
            if (w_accept) begin
                r_started <= !w_frame_end;
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_frame_end ? 13'd0 : w_row_next[12:0];
                end else begin
                    r_col <= w_col_next[12:0];
                end
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_byte_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix   <= i_pix;
            r_fend  <= w_frame_end;
            r_trunc <= !r_started && w_frame_end;
        end
        case (r_state)
            ST_PREP: begin
                r_row_sz     <= 16'({3'd0, w_wc} * 16'd3) + 16'd1;
                r_dq         <= BLOCK_MAX;
                r_rem        <= '0;
                r_dvs        <= 16'({3'd0, w_wc} * 16'd3) + 16'd1;
                r_cnt        <= '0;
                r_alo        <= 16'd1;
                r_ahi        <= 16'd0;
                r_block_left <= '0;
            end
            ST_DIV1, ST_DIV2: begin
                r_dq  <= {r_dq[14:0], w_div_ge};
                r_rem <= w_div_rem;
                r_cnt <= r_cnt + 4'd1;
            end
            ST_MUL1: begin
                r_rpb       <= r_dq;
                r_data_left <= {19'd0, w_hc} * {16'd0, r_row_sz};
            end
            ST_MUL2: begin
                r_full <= w_full_prod[15:0];
                // ceiling divide of rows by rows per block
                r_dq   <= 16'({3'd0, w_hc} + r_rpb - 16'd1);
                r_rem  <= '0;
                r_dvs  <= r_rpb;
                r_cnt  <= '0;
            end
            ST_LEN: r_chunk <= ({16'd0, r_dq} * 32'd5) + 32'd6 + r_data_left;
            default: ;
        endcase
        if (w_emit) begin
            r_out.out_byte <= w_byte;
            r_out.run_last <= w_last;
            r_out.file_end <= w_last && r_fend;
            if (w_crc_init) r_crc <= 32'hFFFFFFFF;
            if (w_crc_en)   r_crc <= crc_byte(r_crc, w_byte);
            if (w_adler_en) begin
                r_alo <= w_alo;
                r_ahi <= w_ahi;
            end
            if (w_data_en) begin
                if (r_block_left != '0) r_block_left <= r_block_left - 16'd1;
                if (r_data_left != '0)  r_data_left  <= r_data_left - 32'd1;
            end
            if (r_phase == PH_BLK_HDR && r_idx == phase_last(PH_BLK_HDR)) begin
                r_block_left <= w_bsize;
            end
        end
    end

    assign o_pix_ready  = (r_state == ST_IDLE);
    assign o_byte_valid = r_ovalid;
    assign o_byte       = r_out;

endmodule
`default_nettype wire

/* hw/rtl/upng_checker.sv */
// Port-level checker for the PNG stream encoder, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module upng_checker
    import upng_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_pix_ready,
    input wire logic                  o_byte_valid,
    input wire logic                  i_byte_ready,
    input wire t_byte_out             o_byte
);

    // a stalled beat stays up
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_byte_valid && !i_byte_ready, o_byte_valid)

    // the image end closes the run of its pixel
    `ASSERT_IMPLIES(a_end_is_last, i_clk, i_rst_n, o_byte_valid && o_byte.file_end,
        o_byte.run_last)

    // no new pixel while a pixel's run is still unfinished
    `ASSERT_IMPLIES(a_busy_in_run, i_clk, i_rst_n, o_byte_valid && !o_byte.run_last,
        !o_pix_ready)

    // reset empties the output register
    `ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_byte_valid)

endmodule

bind uncompressed_png_stream_encoder upng_checker u_upng_checker (.*);
`default_nettype wire
